[rtl/core/pwat_pkg.sv]
`default_nettype none
package pwat_pkg;

	localparam int unsigned ADDR_W  = 64;
	localparam int unsigned COUNT_W = 4;
	localparam int unsigned PAGES_W = 53;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_XLATE = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [2:0]        entry_index;
		logic              entry_is_io;
		logic              entry_prefetch;
		logic [ADDR_W-1:0] entry_bus_base;
		logic [ADDR_W-1:0] entry_cpu_base;
		logic [ADDR_W-1:0] entry_length;
		logic              bar_is_io;
		logic [ADDR_W-1:0] bar_addr;
		logic [ADDR_W-1:0] bar_len;
	} in_item_t;

	typedef struct packed {
		logic               hit;
		logic [2:0]         window_number;
		logic [ADDR_W-1:0]  cpu_addr;
		logic               io_uncached;
		logic [PAGES_W-1:0] page_count;
	} out_item_t;

	typedef struct packed {
		logic              prefetch;
		logic              is_io;
		logic [ADDR_W-1:0] bus_base;
		logic [ADDR_W-1:0] cpu_base;
		logic [ADDR_W-1:0] length;
	} win_entry_t;

	typedef struct packed {
		logic              hit;
		logic              uncached;
		logic [ADDR_W-1:0] cpu_base;
		logic [ADDR_W-1:0] offset;
	} match_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

[rtl/core/pci_window_address_translate.sv]
`default_nettype none
// Bus address window translation.
// Input channel in_valid/in_ready carries in_data. A load item writes one
// window slot in the cycle it transfers and gives no result. A translate item
// searches windows 0 .. window_count-1 in order for the first window of the
// same type that fully contains the BAR and gives one result on the output
// channel out_valid/out_ready with out_data.
// The window table is a synchronous memory read one slot per cycle; the
// search pipeline checks one window per cycle behind a registered read.
// A translate goes from idle into the search, which issues the table reads
// in order and checks each read slot until the first hit or the last window,
// then into the done state (straight from idle when window_count is zero),
// where its result is registered as the block returns to idle and in_ready
// rises. A load leaves in_ready high.
// in_ready is high only while no translate is in progress. A finished result
// waits in the output register; a new item is taken while it waits, and the
// next translate holds its result until the receiver takes the earlier one.
// cfg_we writes window_count from cfg_wdata; counts above WINDOWS search
// WINDOWS slots. Reset clears window_count, the search state and out_valid;
// window slots hold unknown data until loaded.
module pci_window_address_translate #(
	parameter int unsigned WINDOWS    = 8,
	parameter int unsigned PAGE_SHIFT = 12
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire pwat_pkg::in_item_t           in_data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output pwat_pkg::out_item_t               out_data,
	input  wire logic                         cfg_we,
	input  wire logic [pwat_pkg::COUNT_W-1:0] cfg_wdata
);

	localparam int unsigned AW = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
	localparam int unsigned CW = $clog2(WINDOWS + 1);

	pwat_pkg::state_t state_q, state_d;

	logic [pwat_pkg::COUNT_W-1:0] wcount_q;
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                count_d;
	logic [CW-1:0]                issue_q;
	logic                         chk_v_s1;
	logic                         chk_last_s1;
	logic [CW-1:0]                chk_idx_s1;

	logic                          bar_is_io_q;
	logic [pwat_pkg::ADDR_W-1:0]   bar_addr_q;
	logic [pwat_pkg::ADDR_W:0]     bar_end_q;
	logic [pwat_pkg::ADDR_W-1:0]   len_m1_q;

	logic                          hit_q;
	logic                          uncached_q;
	logic [CW-1:0]                 win_q;
	logic [pwat_pkg::ADDR_W-1:0]   cpu_base_q;
	logic [pwat_pkg::ADDR_W-1:0]   offset_q;

	logic                          out_valid_q;
	pwat_pkg::out_item_t           out_q;

	logic                          in_fire;
	logic                          load_fire;
	logic                          xlate_fire;
	logic                          rd_en;
	logic                          chk_hit;
	logic                          chk_miss_end;
	logic                          deliver;
	logic                          wr_en;
	pwat_pkg::win_entry_t          wr_data;
	pwat_pkg::match_t              match;
	logic [pwat_pkg::ADDR_W-1:0]   pages64;

	assign in_fire    = in_valid && in_ready;
	assign load_fire  = in_fire && (in_data.opcode == pwat_pkg::OP_LOAD);
	assign xlate_fire = in_fire && (in_data.opcode == pwat_pkg::OP_XLATE);
	assign wr_en      = load_fire && (int'(in_data.entry_index) < WINDOWS);

	always_comb begin
		wr_data.prefetch = in_data.entry_prefetch;
		wr_data.is_io    = in_data.entry_is_io;
		wr_data.bus_base = in_data.entry_bus_base;
		wr_data.cpu_base = in_data.entry_cpu_base;
		wr_data.length   = in_data.entry_length;
	end

	always_comb begin
		if (int'(wcount_q) > WINDOWS) begin
			count_d = CW'(WINDOWS);
		end else begin
			count_d = CW'(wcount_q);
		end
	end

	pwat_win_table #(
		.WINDOWS(WINDOWS)
	) u_table (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (AW'(in_data.entry_index)),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (issue_q[AW-1:0]),
		.bar_is_io(bar_is_io_q),
		.bar_addr (bar_addr_q),
		.bar_end  (bar_end_q),
		.match    (match)
	);

	assign chk_hit      = chk_v_s1 && match.hit;
	assign chk_miss_end = chk_v_s1 && !match.hit && chk_last_s1;
	assign deliver      = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			pwat_pkg::ST_IDLE: begin
				if (xlate_fire) begin
					state_d = (count_d == '0) ? pwat_pkg::ST_DONE : pwat_pkg::ST_SEARCH;
				end
			end
			pwat_pkg::ST_SEARCH: begin
				if (chk_hit || chk_miss_end) begin
					state_d = pwat_pkg::ST_DONE;
				end
			end
			pwat_pkg::ST_DONE: begin
				if (deliver) begin
					state_d = pwat_pkg::ST_IDLE;
				end
			end
			default: state_d = pwat_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		case (state_q)
			pwat_pkg::ST_IDLE:   in_ready = 1'b1;
			pwat_pkg::ST_SEARCH: rd_en = (issue_q < count_q) && !chk_hit;
			pwat_pkg::ST_DONE:   in_ready = 1'b0;
			default:             in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pwat_pkg::ST_IDLE;
			wcount_q    <= '0;
			count_q     <= '0;
			issue_q     <= '0;
			chk_v_s1    <= 1'b0;
			chk_last_s1 <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				wcount_q <= cfg_wdata;
			end
			chk_v_s1    <= rd_en;
			chk_last_s1 <= rd_en && ((issue_q + CW'(1)) == count_q);
			if (xlate_fire) begin
				count_q <= count_d;
				issue_q <= '0;
				hit_q   <= 1'b0;
			end else if (rd_en) begin
				issue_q <= issue_q + CW'(1);
			end
			if (chk_hit) begin
				hit_q <= 1'b1;
			end
			if (state_q == pwat_pkg::ST_DONE && deliver) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold BAR and matched window for the result stage
	always_ff @(posedge clk) begin
		if (xlate_fire) begin
			bar_is_io_q <= in_data.bar_is_io;
			bar_addr_q  <= in_data.bar_addr;
			bar_end_q   <= {1'b0, in_data.bar_addr} + {1'b0, in_data.bar_len};
			len_m1_q    <= in_data.bar_len - pwat_pkg::ADDR_W'(1);
		end
		if (rd_en) begin
			chk_idx_s1 <= issue_q;
		end
		if (chk_hit) begin
			uncached_q <= match.uncached;
			win_q      <= chk_idx_s1;
			cpu_base_q <= match.cpu_base;
			offset_q   <= match.offset;
		end
	end

	assign pages64 = (len_m1_q >> PAGE_SHIFT) + pwat_pkg::ADDR_W'(1);

	always_ff @(posedge clk) begin
		if (state_q == pwat_pkg::ST_DONE && deliver) begin
			out_q.hit <= hit_q;
			if (hit_q) begin
				out_q.window_number <= 3'(win_q);
				out_q.cpu_addr      <= cpu_base_q + offset_q;
				out_q.io_uncached   <= uncached_q;
				out_q.page_count    <= pages64[pwat_pkg::PAGES_W-1:0];
			end else begin
				out_q.window_number <= '0;
				out_q.cpu_addr      <= '0;
				out_q.io_uncached   <= 1'b0;
				out_q.page_count    <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == pwat_pkg::ST_DONE))
		else $error("result appeared without a finished search");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pwat_pkg::ST_SEARCH |-> issue_q <= count_q)
		else $error("search read past the window count");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.hit) |-> (out_data.window_number == '0 &&
		out_data.cpu_addr == '0 && out_data.page_count == '0 && !out_data.io_uncached))
		else $error("miss result carries nonzero fields");

	a_hit_needs_check: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hit_q) |-> $past(chk_v_s1))
		else $error("hit recorded without a checked window");
`endif

endmodule
`default_nettype wire

[rtl/core/pwat_win_table.sv]
`default_nettype none
module pwat_win_table #(
	parameter int unsigned WINDOWS = 8,
	localparam int unsigned AW = (WINDOWS > 1) ? $clog2(WINDOWS) : 1
) (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic [AW-1:0]               wr_addr,
	input  wire pwat_pkg::win_entry_t        wr_data,
	input  wire logic                        rd_en,
	input  wire logic [AW-1:0]               rd_addr,
	input  wire logic                        bar_is_io,
	input  wire logic [pwat_pkg::ADDR_W-1:0] bar_addr,
	input  wire logic [pwat_pkg::ADDR_W:0]   bar_end,
	output pwat_pkg::match_t                 match
);

	pwat_pkg::win_entry_t mem_q [WINDOWS];
	pwat_pkg::win_entry_t rd_q;
	logic [pwat_pkg::ADDR_W:0] win_end;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign win_end = {1'b0, rd_q.bus_base} + {1'b0, rd_q.length};

	always_comb begin
		match.hit      = (rd_q.is_io == bar_is_io) && (rd_q.bus_base <= bar_addr)
		                 && (win_end >= bar_end);
		match.uncached = ~rd_q.prefetch;
		match.cpu_base = rd_q.cpu_base;
		match.offset   = bar_addr - rd_q.bus_base;
	end

endmodule
`default_nettype wire
